// File: hdl/wst_pkg.sv
// Shared constants, register codes and sine table functions for the WAV tone streamer.
`default_nettype none

package wst_pkg;

  localparam int unsigned SINE_TABLE_BITS_DEF   = 12;
  localparam int unsigned SAMPLE_COUNT_BITS_DEF = 24;

  localparam int unsigned HEADER_LEN  = 44;
  localparam int unsigned FULL_SCALE  = 32767;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam int unsigned RATE_W  = 24;
  localparam int unsigned STEP_W  = 32;
  localparam int unsigned COUNT_W = 24;
  localparam int unsigned CFG_W   = 32;

  localparam logic [RATE_W-1:0]  SAMPLE_RATE_RST = 24'd44100;
  localparam logic [STEP_W-1:0]  PHASE_STEP_RST  = 32'd42852281;
  localparam logic [COUNT_W-1:0] NUM_SAMPLES_RST = 24'd22050;

  typedef enum logic [1:0] {
    REG_SAMPLE_RATE = 2'd0,
    REG_PHASE_STEP  = 2'd1,
    REG_NUM_SAMPLES = 2'd2,
    REG_UNUSED      = 2'd3
  } cfg_reg_e;

  // Fixed bytes of the RIFF/WAVE header; computed fields read as zero here.
  function automatic logic [7:0] header_template(input logic [5:0] p);
    logic [7:0] b;
    b = 8'h00;
    unique case (p)
      6'd0:  b = 8'h52;
      6'd1:  b = 8'h49;
      6'd2:  b = 8'h46;
      6'd3:  b = 8'h46;
      6'd8:  b = 8'h57;
      6'd9:  b = 8'h41;
      6'd10: b = 8'h56;
      6'd11: b = 8'h45;
      6'd12: b = 8'h66;
      6'd13: b = 8'h6d;
      6'd14: b = 8'h74;
      6'd15: b = 8'h20;
      6'd16: b = 8'd16;
      6'd20: b = 8'h01;
      6'd22: b = 8'd1;
      6'd32: b = 8'd2;
      6'd34: b = 8'd16;
      6'd36: b = 8'h64;
      6'd37: b = 8'h61;
      6'd38: b = 8'h74;
      6'd39: b = 8'h61;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Quarter-wave sine magnitude in Q15, evaluated at elaboration only.
  function automatic logic [14:0] quarter_sine(input int unsigned q, input int unsigned tb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] mag;
    logic [63:0] v;
    int unsigned quarter;
    quarter = 1 << (tb - 2);
    if (q == 0) return 15'd0;
    if (q >= quarter) return 15'(FULL_SCALE);
    x    = (64'(q) * HALF_PI_Q30) >> (tb - 2);
    x2   = (x * x) >> 30;
    term = x;
    pos  = x;
    neg  = '0;
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) neg = neg + term;
      else              pos = pos + term;
    end
    mag = (pos > neg) ? pos - neg : 64'd0;
    v   = (mag * 64'(FULL_SCALE)) >> 30;
    return (v > 64'(FULL_SCALE)) ? 15'(FULL_SCALE) : v[14:0];
  endfunction

endpackage

`default_nettype wire

// File: hdl/wav_sine_tone_byte_stream_core.sv
// WAV tone byte streamer: header generation, phase accumulator and sine ROM pipeline.
`default_nettype none

// Streams a mono 16-bit PCM WAV file one byte per transfer: the 44-byte header
// (sizes and rates taken live from the config registers), then the sine samples low
// byte first, then wraps to header byte 0 with zero phase. A set restart bit in an
// input transfer starts the file over at that byte. The core sustains one byte per
// clock unless the output stalls; each byte passes the registered read of the
// quarter-wave sine ROM (2^(SINE_TABLE_BITS-2)+1 entries of 15 bits) and the output
// register. Config writes are always taken and should be made only while idle.
module wav_sine_tone_byte_stream_core
  import wst_pkg::*;
#(
  parameter int unsigned SINE_TABLE_BITS   = SINE_TABLE_BITS_DEF,
  parameter int unsigned SAMPLE_COUNT_BITS = SAMPLE_COUNT_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [1:0]       cfg_index_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [7:0]       s_axis_tdata,   // [0] restart, [7:1] zero
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [7:0]            m_axis_tdata,   // [7:0] out_byte
  output logic                  m_axis_tuser,   // [0] in_header
  output logic                  m_axis_tlast
);

  localparam int unsigned TB    = SINE_TABLE_BITS;
  localparam int unsigned QA_W  = TB - 1;
  localparam int unsigned QTR   = 1 << (TB - 2);
  localparam int unsigned NS_W  = (SAMPLE_COUNT_BITS < COUNT_W) ? SAMPLE_COUNT_BITS : COUNT_W;
  localparam int unsigned POS_W = SAMPLE_COUNT_BITS + 2;

  typedef logic [14:0] qtab_t [QTR+1];

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int i = 0; i <= int'(QTR); i++) begin
      t[i] = quarter_sine(i, TB);
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  // config registers
  logic [RATE_W-1:0]  sample_rate_q;
  logic [STEP_W-1:0]  phase_step_q;
  logic [COUNT_W-1:0] num_samples_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_rate_q <= SAMPLE_RATE_RST;
      phase_step_q  <= PHASE_STEP_RST;
      num_samples_q <= NUM_SAMPLES_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SAMPLE_RATE: sample_rate_q <= cfg_data_i[RATE_W-1:0];
        REG_PHASE_STEP:  phase_step_q  <= cfg_data_i[STEP_W-1:0];
        REG_NUM_SAMPLES: num_samples_q <= cfg_data_i[COUNT_W-1:0];
        REG_UNUSED:      ;
        default:         ;
      endcase
    end
  end

  // stream state
  logic [POS_W-1:0] pos_q, pos_d;
  logic [31:0]      phase_q, phase_d;
  logic [7:0]       held_q;

  // pipeline registers
  logic             s1_valid_q, out_valid_q;
  logic             s1_hdr_q, s1_last_q, s1_even_q, s1_neg_q;
  logic [7:0]       s1_hbyte_q;
  logic [14:0]      rom_q;
  logic [7:0]       out_byte_q;
  logic             out_hdr_q, out_last_q;

  logic             out_adv, in_acc, start;
  logic [NS_W-1:0]  ns_eff;
  logic [POS_W-1:0] total, p;
  logic [31:0]      ph, data_size, word;
  logic             is_hdr, is_even, is_last;
  logic [7:0]       hbyte;
  logic [TB-1:0]    idx;
  logic [QA_W-1:0]  qaddr;
  logic [15:0]      sample;

  assign out_adv       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || out_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign ns_eff    = num_samples_q[NS_W-1:0];
  assign total     = POS_W'(HEADER_LEN) + POS_W'({ns_eff, 1'b0});
  assign data_size = 32'({ns_eff, 1'b0});
  assign start     = s_axis_tdata[0] || (pos_q >= total);
  assign p         = start ? '0 : pos_q;
  assign ph        = start ? '0 : phase_q;
  assign is_hdr    = p < POS_W'(HEADER_LEN);
  assign is_even   = !is_hdr && !p[0];
  assign is_last   = p == total - POS_W'(1);

  always_comb begin
    word = '0;
    priority if (p >= POS_W'(4) && p < POS_W'(8))   word = 32'd36 + data_size;
    else if (p >= POS_W'(24) && p < POS_W'(28))     word = 32'(sample_rate_q);
    else if (p >= POS_W'(28) && p < POS_W'(32))     word = 32'({sample_rate_q, 1'b0});
    else if (p >= POS_W'(40) && p < POS_W'(44))     word = data_size;
    else                                            word = '0;
    hbyte = header_template(p[5:0]) | 8'(word >> {p[1:0], 3'b000});
  end

  assign idx   = ph[31 -: TB];
  assign qaddr = idx[TB-2] ? (QA_W'(QTR) - QA_W'(idx[TB-3:0])) : QA_W'(idx[TB-3:0]);

  always_comb begin
    pos_d   = is_last ? '0 : p + POS_W'(1);
    phase_d = is_last ? '0 : (is_even ? ph + phase_step_q : ph);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= '0;
    end else if (in_acc) begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
    end
  end

  // stage 1: sine ROM read and header byte
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rom_q      <= QTAB[qaddr];
      s1_neg_q   <= idx[TB-1];
      s1_hdr_q   <= is_hdr;
      s1_last_q  <= is_last;
      s1_even_q  <= is_even;
      s1_hbyte_q <= hbyte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      held_q      <= '0;
    end else begin
      if (s_axis_tready) s1_valid_q <= s_axis_tvalid;
      if (out_adv) out_valid_q <= s1_valid_q;
      if (out_adv && s1_valid_q && s1_even_q) held_q <= sample[15:8];
    end
  end

  // stage 2: sign, byte select, output register
  assign sample = s1_neg_q ? (16'd0 - {1'b0, rom_q}) : {1'b0, rom_q};

  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      out_byte_q <= s1_hdr_q ? s1_hbyte_q : (s1_even_q ? sample[7:0] : held_q);
      out_hdr_q  <= s1_hdr_q;
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_hdr_q;
  assign m_axis_tlast  = out_last_q;

  a_ready_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with pipeline not full");

  a_restart_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tdata[0]) |=> (pos_q == POS_W'(1)))
    else $error("restart did not resume at header byte 1");

  a_phase_zero_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q == '0) |-> (phase_q == '0))
    else $error("phase not cleared at file start");

endmodule

`default_nettype wire
